[design/ct_transfer_function_lookup_macros.svh]
// ----------------------------------------------------------------------------
// Transfer function lookup assertion macros
// Concurrent assertion wrappers clocked on clk_i and reset by rst_ni; they
// compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CT_TRANSFER_FUNCTION_LOOKUP_MACROS_SVH
`define CT_TRANSFER_FUNCTION_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS
`define CT_TFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CT_TFL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CT_TFL_ASSERT(lbl, prop, msg)
`define CT_TFL_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[design/ct_tfl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer function lookup package
// Widths, pipeline stage numbering, register map and shared types.
// ----------------------------------------------------------------------------
package ct_tfl_pkg;

  localparam int CT_POINTS  = 4;
  localparam int LANES      = 4;
  localparam int POS_W      = 16;
  localparam int CH_W       = 8;
  localparam int LOOK_W     = LANES * CH_W;
  localparam int OFF_W      = POS_W;
  localparam int PROD_W     = CH_W + OFF_W;
  localparam int PT_IDX_W   = $clog2(CT_POINTS);

  // Register map: positions first, then looks.
  localparam int CFG_IDX_W  = $clog2(2 * CT_POINTS);
  localparam int CFG_DATA_W = LOOK_W;
  localparam int REG_POS_BASE  = 0;
  localparam int REG_LOOK_BASE = CT_POINTS;

  // Channel lanes, lane 0 takes the top byte of a look.
  localparam int LANE_OPACITY = 0;
  localparam int LANE_RED     = 1;
  localparam int LANE_GREEN   = 2;
  localparam int LANE_BLUE    = 3;

  // Pipeline stages.
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = CH_W / DIV_BITS;
  localparam int ST_LOC     = 0;
  localparam int ST_PREP    = 1;
  localparam int ST_MUL     = 2;
  localparam int ST_DIV0    = 3;
  localparam int ST_FIN     = ST_DIV0 + DIV_STAGES;
  localparam int N_STAGES   = ST_FIN + 1;

  typedef logic [CT_POINTS-1:0][POS_W-1:0]  pos_arr_t;
  typedef logic [CT_POINTS-1:0][LOOK_W-1:0] look_arr_t;

  localparam pos_arr_t POS_RESET = {16'h0BFF, 16'h0281, 16'hFFF0, 16'hF800};
  localparam look_arr_t LOOK_RESET = {32'hB5FF_FFFF, 32'hB8E6_D18F,
                                      32'h00BA_404D, 32'h0000_0000};

  typedef struct packed {
    logic                  loc;
    logic                  prep;
    logic                  mul;
    logic [DIV_STAGES-1:0] div;
    logic                  fin;
  } pipe_en_t;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] span;
  } prep_t;

  typedef struct packed {
    logic [CH_W-1:0] base;
    logic [CH_W-1:0] mag;
    logic            neg;
  } lane_op_t;

  typedef lane_op_t [LANES-1:0] lane_ops_t;

endpackage

[design/ct_tfl_locate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer function segment locate
// Finds the segment of the sample and prepares offset, span and per-lane
// operands over two register stages.
// ----------------------------------------------------------------------------
module ct_tfl_locate (
  input  logic                  clk_i,
  input  ct_tfl_pkg::pipe_en_t  en_i,
  input  logic [15:0]           sample_i,
  input  ct_tfl_pkg::pos_arr_t  pos_i,
  input  ct_tfl_pkg::look_arr_t look_i,
  output ct_tfl_pkg::prep_t     prep_o,
  output ct_tfl_pkg::lane_ops_t ops_o
);
  import ct_tfl_pkg::*;

  logic [POS_W-1:0]     x_q;
  logic [CT_POINTS-1:0] lo_oh_d, hi_oh_d, lo_oh_q, hi_oh_q;
  logic                 interp_d, interp_q;

  logic [POS_W-1:0]  p0, p1;
  logic [LOOK_W-1:0] lk_lo, lk_hi;
  logic [POS_W:0]    off_w, span_w;
  prep_t             prep_d, prep_q;
  lane_ops_t         ops_d, ops_q;

  // First point strictly above the sample; none found selects the last point.
  always_comb begin
    logic found;
    found    = 1'b0;
    hi_oh_d  = '0;
    interp_d = 1'b0;
    for (int i = 0; i < CT_POINTS; i++) begin
      if (!found && ($signed(sample_i) < $signed(pos_i[i]))) begin
        found      = 1'b1;
        hi_oh_d[i] = 1'b1;
        interp_d   = (i != 0);
      end
    end
    if (!found) begin
      hi_oh_d[CT_POINTS-1] = 1'b1;
    end
    lo_oh_d = interp_d ? (hi_oh_d >> 1) : hi_oh_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.loc) begin
      x_q      <= sample_i;
      lo_oh_q  <= lo_oh_d;
      hi_oh_q  <= hi_oh_d;
      interp_q <= interp_d;
    end
  end

  always_comb begin
    p0    = '0;
    p1    = '0;
    lk_lo = '0;
    lk_hi = '0;
    for (int i = 0; i < CT_POINTS; i++) begin
      if (lo_oh_q[i]) begin
        p0    = p0 | pos_i[i];
        lk_lo = lk_lo | look_i[i];
      end
      if (hi_oh_q[i]) begin
        p1    = p1 | pos_i[i];
        lk_hi = lk_hi | look_i[i];
      end
    end
    off_w  = {x_q[POS_W-1], x_q} - {p0[POS_W-1], p0};
    span_w = {p1[POS_W-1], p1} - {p0[POS_W-1], p0};
    // Outside any segment both looks are the same point, so the slope is zero.
    prep_d.off  = interp_q ? off_w[OFF_W-1:0] : '0;
    prep_d.span = interp_q ? span_w[OFF_W-1:0] : OFF_W'(1);
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [CH_W-1:0] a, b;
    logic [CH_W:0]   diff, mag;
    assign a    = lk_lo[CH_W*(LANES-1-l) +: CH_W];
    assign b    = lk_hi[CH_W*(LANES-1-l) +: CH_W];
    assign diff = {1'b0, b} - {1'b0, a};
    assign mag  = diff[CH_W] ? (~diff + 1'b1) : diff;
    assign ops_d[l].base = a;
    assign ops_d[l].mag  = mag[CH_W-1:0];
    assign ops_d[l].neg  = diff[CH_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prep) begin
      prep_q <= prep_d;
      ops_q  <= ops_d;
    end
  end

  assign prep_o = prep_q;
  assign ops_o  = ops_q;

endmodule

[design/ct_tfl_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer function channel lane
// Multiplies the slope magnitude by the offset, divides by the span with a
// pipelined restoring divider and adds the signed quotient to the base.
// ----------------------------------------------------------------------------
module ct_tfl_lane (
  input  logic                  clk_i,
  input  ct_tfl_pkg::pipe_en_t  en_i,
  input  ct_tfl_pkg::prep_t     prep_i,
  input  ct_tfl_pkg::lane_op_t  op_i,
  output logic [7:0]            value_o
);
  import ct_tfl_pkg::*;

  // Index 0 holds the product stage; index k+1 the output of divide stage k.
  logic [PROD_W-1:0] rem_q  [DIV_STAGES];
  logic [OFF_W-1:0]  span_q [DIV_STAGES];
  logic [CH_W-1:0]   quo_q  [DIV_STAGES+1];
  logic [CH_W-1:0]   base_q [DIV_STAGES+1];
  logic              neg_q  [DIV_STAGES+1];
  logic [CH_W:0]     sum;
  logic [CH_W-1:0]   value_q;

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      rem_q[0]  <= PROD_W'(op_i.mag) * PROD_W'(prep_i.off);
      span_q[0] <= prep_i.span;
      quo_q[0]  <= '0;
      base_q[0] <= op_i.base;
      neg_q[0]  <= op_i.neg;
    end
  end

  // The quotient is below the slope magnitude, so eight bits always suffice.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [PROD_W-1:0] rem_d;
    logic [CH_W-1:0]   quo_d;

    always_comb begin
      logic [PROD_W-1:0] sh;
      rem_d = rem_q[k];
      quo_d = quo_q[k];
      for (int b = 0; b < DIV_BITS; b++) begin
        sh = PROD_W'(span_q[k]) << (CH_W - 1 - (DIV_BITS * k + b));
        if (rem_d >= sh) begin
          rem_d = rem_d - sh;
          quo_d[CH_W - 1 - (DIV_BITS * k + b)] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i.div[k]) begin
        quo_q[k+1]  <= quo_d;
        base_q[k+1] <= base_q[k];
        neg_q[k+1]  <= neg_q[k];
      end
    end

    if (k < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i.div[k]) begin
          rem_q[k+1]  <= rem_d;
          span_q[k+1] <= span_q[k];
        end
      end
    end else begin : g_last
      logic unused_rem;
      assign unused_rem = ^rem_d;
    end
  end

  assign sum = neg_q[DIV_STAGES] ? ({1'b0, base_q[DIV_STAGES]} - {1'b0, quo_q[DIV_STAGES]})
                                 : ({1'b0, base_q[DIV_STAGES]} + {1'b0, quo_q[DIV_STAGES]});

  always_ff @(posedge clk_i) begin
    if (en_i.fin) begin
      value_q <= sum[CH_W-1:0];
    end
  end

  assign value_o = value_q;

endmodule

[design/ct_transfer_function_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CT transfer function lookup
// Piecewise-linear opacity and color lookup of one signed CT sample against
// four control points.
// ----------------------------------------------------------------------------
// When nothing stalls, the block takes one sample word per clock and returns
// one word of opacity, red, green and blue for each accepted sample.
// The pipeline stages are segment compare, operand select, one multiply per
// channel, four restoring divide stages of two quotient bits each, and the
// output register. Up to eight words are in flight; when the output stalls,
// the stages behind it keep filling bubbles, so input is held off only once
// every stage holds a word. Control points are written through the
// configuration port while the block is idle, and must be in ascending
// order of position for the usual result; the block itself enforces neither.
// A sample below the first point returns the first point's look, and one at
// or above the last point returns the last point's look.
module ct_transfer_function_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [ct_tfl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ct_tfl_pkg::CFG_DATA_W-1:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  opacity_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);
  import ct_tfl_pkg::*;

`include "ct_transfer_function_lookup_macros.svh"

  pos_arr_t  pos_q;
  look_arr_t look_q;

  logic [N_STAGES-1:0] vld_q, vld_in, rdy;
  pipe_en_t            en;
  prep_t               prep;
  lane_ops_t           ops;
  logic [CH_W-1:0]     lane_val [LANES];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_RESET;
      look_q <= LOOK_RESET;
    end else if (cfg_we_i) begin
      for (int i = 0; i < CT_POINTS; i++) begin
        if (cfg_idx_i == CFG_IDX_W'(REG_POS_BASE + i)) begin
          pos_q[i] <= cfg_data_i[POS_W-1:0];
        end
        if (cfg_idx_i == CFG_IDX_W'(REG_LOOK_BASE + i)) begin
          look_q[i] <= cfg_data_i[LOOK_W-1:0];
        end
      end
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    rdy[N_STAGES-1] = !vld_q[N_STAGES-1] || !out_stall_i;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vld_in = {vld_q[N_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < N_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign en.loc  = rdy[ST_LOC];
  assign en.prep = rdy[ST_PREP];
  assign en.mul  = rdy[ST_MUL];
  assign en.div  = rdy[ST_DIV0 +: DIV_STAGES];
  assign en.fin  = rdy[ST_FIN];

  ct_tfl_locate u_locate (
    .clk_i    (clk_i),
    .en_i     (en),
    .sample_i (sample_i),
    .pos_i    (pos_q),
    .look_i   (look_q),
    .prep_o   (prep),
    .ops_o    (ops)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    ct_tfl_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .prep_i  (prep),
      .op_i    (ops[l]),
      .value_o (lane_val[l])
    );
  end

  assign in_stall_o  = !rdy[ST_LOC];
  assign out_valid_o = vld_q[ST_FIN];
  assign opacity_o   = lane_val[LANE_OPACITY];
  assign red_o       = lane_val[LANE_RED];
  assign green_o     = lane_val[LANE_GREEN];
  assign blue_o      = lane_val[LANE_BLUE];

  // Input is held off only with every stage occupied behind a stalled output.
  `CT_TFL_ASSERT(a_stall_only_full, in_stall_o |-> ((&vld_q) && out_stall_i), "input stalled with room in the pipeline")
  // An accepted word lands in the first stage.
  `CT_TFL_ASSERT(a_accept_lands, (in_valid_i && !in_stall_o) |=> vld_q[ST_LOC], "accepted word lost at entry")
  // A word never waits in front of an empty stage.
  `CT_TFL_ASSERT_NEVER(a_no_idle_gap, $past(vld_q[ST_LOC] && !vld_q[ST_PREP]) && !vld_q[ST_PREP] && rst_ni && $past(rst_ni), "word failed to advance into a free stage")

endmodule

[tb/sv/ct_tfl_lookup_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer function lookup checker
// Watches the configuration port and both word channels. It predicts opacity,
// red, green and blue for every accepted sample and compares each returned
// word with the oldest prediction.
// ----------------------------------------------------------------------------
module ct_tfl_lookup_checker
  import ct_tfl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [15:0]           sample_i,

  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [7:0]            opacity_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,

  output int                    mismatch_count_o,
  output int                    words_due_o
);

  localparam int NUM_POINTS = CT_POINTS;

  typedef struct packed {
    logic [7:0] opacity;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgba_t;

  logic signed [15:0] point_pos [NUM_POINTS];
  logic [31:0]        point_look [NUM_POINTS];
  rgba_t              rgba_due_q [$];
  int                 mismatch_count = 0;

  assign mismatch_count_o = mismatch_count;

  // The first point strictly above the sample closes the segment. Below the
  // first point the first look is returned, and with no point above the
  // sample the last look is returned.
  function automatic rgba_t lookup_color(input logic signed [15:0] x);
    int          hit;
    longint      span;
    longint      off;
    longint      lo;
    longint      hi;
    logic [31:0] word;
    hit = -1;
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (hit < 0 && x < point_pos[i]) hit = i;
    end
    if (hit == 0) begin
      word = point_look[0];
    end else if (hit < 0) begin
      word = point_look[NUM_POINTS-1];
    end else begin
      // The point before the hit is never above the sample, so the span is
      // positive even when the points are out of order.
      span = longint'(point_pos[hit]) - longint'(point_pos[hit-1]);
      off  = longint'(x) - longint'(point_pos[hit-1]);
      for (int k = 0; k < 4; k++) begin
        lo = longint'(point_look[hit-1][8*k +: 8]);
        hi = longint'(point_look[hit][8*k +: 8]);
        word[8*k +: 8] = 8'(lo + ((hi - lo) * off) / span);
      end
    end
    return rgba_t'(word);
  endfunction

  function automatic void check_lane(input string lane, input logic [7:0] want,
                                     input logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d, actual %0d", lane, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    rgba_t want;
    if (!rst_ni) begin
      point_pos[0]  = -16'sd2048;
      point_pos[1]  = -16'sd16;
      point_pos[2]  = 16'sd641;
      point_pos[3]  = 16'sd3071;
      point_look[0] = 32'h0000_0000;
      point_look[1] = 32'h00BA_404D;
      point_look[2] = 32'hB8E6_D18F;
      point_look[3] = 32'hB5FF_FFFF;
      rgba_due_q.delete();
      words_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < REG_LOOK_BASE) begin
          point_pos[cfg_idx_i - REG_POS_BASE] = cfg_data_i[15:0];
        end else begin
          point_look[cfg_idx_i - REG_LOOK_BASE] = cfg_data_i;
        end
      end
      // Results are retired before new samples are queued, so a word that
      // leaves in the same cycle as a sample enters never matches that sample.
      if (out_valid_i && !out_stall_i) begin
        if (rgba_due_q.size() == 0) begin
          $error("result word with no sample outstanding");
          mismatch_count++;
        end else begin
          want = rgba_due_q.pop_front();
          check_lane("opacity", want.opacity, opacity_i);
          check_lane("red", want.red, red_i);
          check_lane("green", want.green, green_i);
          check_lane("blue", want.blue, blue_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        rgba_due_q.push_back(lookup_color($signed(sample_i)));
      end
      words_due_o <= rgba_due_q.size();
    end
  end

endmodule

[tb/sv/tb_ct_transfer_function_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CT transfer function lookup testbench
// Drives sample words through the lookup under random sender gaps and
// receiver stalls, reprograms the control points between phases, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_ct_transfer_function_lookup;

  import ct_tfl_pkg::*;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [15:0]           sample_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            opacity_o;
  logic [7:0]            red_o;
  logic [7:0]            green_o;
  logic [7:0]            blue_o;
  int                    mismatch_count;
  int                    words_due;

  // Positions as currently programmed. The sample picker steers toward them
  // so that most words land inside a segment or right on a point.
  int pos_now [4] = '{-2048, -16, 641, 3071};

  // Directed samples for the reset points: both extremes of the field, zero,
  // each point and its neighbors on both sides, one sample inside each
  // segment, and the two alternating bit patterns.
  int directed_samples [20] = '{-32768, 32767, 0, -1, -2049, -2048, -2047,
                                -17, -16, -15, 640, 641, 642, 3070, 3071,
                                3072, -1032, 300, 21845, -21846};

  int stall_mode = 0;
  int stall_left = 0;

  ct_transfer_function_lookup u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .opacity_o   (opacity_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  ct_tfl_lookup_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .sample_i         (sample_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .opacity_i        (opacity_o),
    .red_i            (red_o),
    .green_i          (green_o),
    .blue_i           (blue_o),
    .mismatch_count_o (mismatch_count),
    .words_due_o      (words_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver switches between stall patterns at random: no stall at all,
  // light random stalls, heavy random stalls, and long runs of stall that back
  // the pipeline up until the block holds off its input. Random switching lets
  // the gaps land on every pipeline stage.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ((stall_left % 16) < 11);
    endcase
  end

  // A sample is full range three times in ten, on or next to a point twice
  // in ten, and otherwise somewhere between the lowest and highest point.
  function automatic logic [15:0] pick_sample();
    int lo;
    int hi;
    int v;
    lo = pos_now[0];
    hi = pos_now[0];
    for (int i = 1; i < 4; i++) begin
      if (pos_now[i] < lo) lo = pos_now[i];
      if (pos_now[i] > hi) hi = pos_now[i];
    end
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
      3, 4:    v = pos_now[$urandom_range(0, 3)] + int'($urandom_range(0, 2)) - 1;
      default: v = lo + int'($urandom_range(0, hi - lo));
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  // Four random positions in ascending order; equal neighbors may occur.
  function automatic logic [3:0][15:0] ascending_positions();
    int pick [4];
    int swap;
    logic [3:0][15:0] pos_set;
    for (int i = 0; i < 4; i++) pick[i] = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3 - i; j++) begin
        if (pick[j] > pick[j+1]) begin
          swap      = pick[j];
          pick[j]   = pick[j+1];
          pick[j+1] = swap;
        end
      end
    end
    for (int i = 0; i < 4; i++) pos_set[i] = 16'(pick[i]);
    return pos_set;
  endfunction

  // Offers one sample word and holds it until the block takes it. The stall
  // seen right after the edge is the value that edge acted on.
  task automatic send_sample(input logic [15:0] v);
    in_valid_i <= 1'b1;
    sample_i   <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Bursts of back-to-back words with random gaps between them; a quarter of
  // the bursts run straight into the next one with no gap.
  task automatic stream_samples(input int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_sample(pick_sample());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // The checker updates its count of outstanding words with a nonblocking
  // assignment, so the value read after an edge covers every acceptance up
  // to the edge before. Waiting for an edge first makes the last sample count.
  task automatic wait_drained();
    do @(posedge clk_i); while (words_due != 0);
  endtask

  // Writes all eight registers, positions first. The upper half of each
  // position write carries random bits that the block must ignore.
  task automatic program_points(input logic [3:0][15:0] pos_set,
                                input logic [3:0][31:0] look_set);
    for (int r = 0; r < CT_POINTS; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(REG_POS_BASE + r);
      cfg_data_i <= {16'($urandom), pos_set[r]};
      @(posedge clk_i);
    end
    for (int r = 0; r < CT_POINTS; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(REG_LOOK_BASE + r);
      cfg_data_i <= look_set[r];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    for (int r = 0; r < 4; r++) pos_now[r] = $signed(pos_set[r]);
  endtask

  initial begin : stimulus
    logic [3:0][15:0] pos_set;
    logic [3:0][31:0] look_set;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words against the reset points, sent back to back. The sender
    // then pauses until every result has come back before going random.
    for (int k = 0; k < 20; k++) send_sample(16'(directed_samples[k]));
    in_valid_i <= 1'b0;
    wait_drained();
    stream_samples(150);
    wait_drained();

    // Random ascending points with random looks.
    pos_set = ascending_positions();
    for (int i = 0; i < 4; i++) look_set[i] = $urandom;
    program_points(pos_set, look_set);
    stream_samples(200);
    wait_drained();

    // Points at the ends of the field with looks swinging between all zeros
    // and all ones, so every channel takes its widest rise across half the
    // field and its widest fall within a unit span.
    pos_set[0]  = 16'h8000;
    pos_set[1]  = 16'hFFFF;
    pos_set[2]  = 16'h0000;
    pos_set[3]  = 16'h7FFF;
    look_set[0] = 32'h0000_0000;
    look_set[1] = 32'hFFFF_FFFF;
    look_set[2] = 32'h0000_0000;
    look_set[3] = 32'hFFFF_FFFF;
    program_points(pos_set, look_set);
    stream_samples(150);
    wait_drained();

    // Unit spans: every segment is one sample wide.
    pos_set[0] = 16'($urandom_range(0, 65532));
    for (int i = 1; i < 4; i++) pos_set[i] = pos_set[i-1] + 16'd1;
    if ($signed(pos_set[0]) > 16'sd32764) pos_set[0] = 16'h7FFC;
    for (int i = 1; i < 4; i++) pos_set[i] = pos_set[i-1] + 16'd1;
    for (int i = 0; i < 4; i++) look_set[i] = $urandom;
    program_points(pos_set, look_set);
    stream_samples(100);
    wait_drained();

    // Points in random order: the first point above the sample still decides.
    for (int i = 0; i < 4; i++) begin
      pos_set[i]  = 16'($urandom);
      look_set[i] = $urandom;
    end
    program_points(pos_set, look_set);
    stream_samples(200);
    wait_drained();

    // Two equal middle points, with the last point at the top of the field.
    pos_set[0]  = -16'sd100;
    pos_set[1]  = 16'sd500;
    pos_set[2]  = 16'sd500;
    pos_set[3]  = 16'h7FFF;
    look_set[0] = 32'hFFFF_FFFF;
    look_set[1] = 32'h0000_0000;
    look_set[2] = 32'hFFFF_FFFF;
    look_set[3] = 32'h0000_0000;
    program_points(pos_set, look_set);
    stream_samples(100);
    wait_drained();

    // First and last points pinned to the field's extremes, random middle.
    pos_set    = ascending_positions();
    pos_set[0] = 16'h8000;
    pos_set[3] = 16'h7FFF;
    for (int i = 0; i < 4; i++) look_set[i] = $urandom;
    program_points(pos_set, look_set);
    stream_samples(100);

    // Let the pipeline empty, then keep the clock running so that any stray
    // word shows before the verdict.
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ct_transfer_function_lookup verification clean");
    end else begin
      $display("ct_transfer_function_lookup verification failed");
    end
    $finish;
  end

  // The slowest correct run is well under a tenth of this.
  initial begin : watchdog
    #5_000_000;
    $display("ct_transfer_function_lookup verification failed");
    $finish;
  end

endmodule
